[hdl/isotp_pkg.sv]
// Shared types and constants of the ISO-TP frame reassembler.
`default_nettype none

package isotp_pkg;

    localparam int MAX_MESSAGE = 4095;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [3:0] FULL_FRAME = 4'd8;
    localparam logic [2:0] FF_CHUNK = 3'd6;
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 56;
    localparam int PADDR_W = 3;

    // Register byte addresses
    localparam logic [PADDR_W-1:0] ADDR_TIMEOUT = 3'd0;

    // PCI nibble codes
    localparam logic [3:0] PCI_SF = 4'h0;
    localparam logic [3:0] PCI_FF = 4'h1;
    localparam logic [3:0] PCI_CF = 4'h2;
    localparam logic [3:0] PCI_FC = 4'h3;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_COMPLETE = 3'd1,
        ST_BAD_PCI  = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_BAD_SEQ  = 3'd4,
        ST_NO_FF    = 3'd5
    } status_t;

    // One input's worth of work for the emitter
    typedef struct packed {
        logic [6:0][7:0] bytes;   // already aligned: bytes[0] is the first message byte
        logic [2:0]      count;
        logic [11:0]     base;
        status_t         status;
        logic            fc;
        logic            to;
        logic [7:0]      snd;
        logic [7:0]      tag;
        logic [11:0]     total;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic        is_byte;
        logic [7:0]  out_byte;
        logic [11:0] out_offset;
        status_t     status;
        logic        fc;
        logic        to;
        logic [7:0]  snd;
        logic [7:0]  tag;
        logic [11:0] total;
        logic        last;
    } item_t;

endpackage

`default_nettype wire

[hdl/isotp_front.sv]
// Front end: accepts frames and ticks, tracks reassembly state, issues jobs.
`default_nettype none

module isotp_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [isotp_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                              s_tuser,
    input  wire logic [15:0]                       timeout_ticks,
    input  wire isotp_pkg::q_status_t              q_stat,
    output logic                                   q_push,
    output isotp_pkg::job_t                        q_job
);
    import isotp_pkg::*;

    logic        waiting_reg, waiting_next;
    logic [7:0]  peer_reg, peer_next;
    logic [7:0]  tag_reg, tag_next;
    logic [11:0] total_reg, total_next;
    logic [11:0] rcvd_reg, rcvd_next;
    logic [3:0]  seq_reg, seq_next;
    logic [15:0] ticks_reg, ticks_next;

    logic [7:0]      in_tag, in_sender;
    logic [3:0]      in_len_raw, len;
    logic [7:0][7:0] b;
    logic [3:0]      pci, low;
    logic [11:0]     ff_total, rem, new_rcvd;
    logic [3:0]      avail;
    logic [2:0]      take;
    logic [15:0]     lim, ticks_inc;
    logic            accept;

    assign in_tag     = s_tdata[7:0];
    assign in_sender  = s_tdata[15:8];
    assign in_len_raw = s_tdata[19:16];
    assign b          = s_tdata[83:20];

    assign len      = (in_len_raw > FULL_FRAME) ? FULL_FRAME : in_len_raw;
    assign pci      = b[0][7:4];
    assign low      = b[0][3:0];
    assign ff_total = {low, b[1]};
    assign rem      = (total_reg > rcvd_reg) ? (total_reg - rcvd_reg) : 12'd0;
    assign avail    = len - 4'd1;
    assign take     = (rem < {8'd0, avail}) ? rem[2:0] : avail[2:0];
    assign new_rcvd = rcvd_reg + {9'd0, take};
    assign lim      = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
    assign ticks_inc = (ticks_reg == 16'hFFFF) ? ticks_reg : ticks_reg + 16'd1;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept;

    always_comb
    begin
        waiting_next = waiting_reg;
        peer_next    = peer_reg;
        tag_next     = tag_reg;
        total_next   = total_reg;
        rcvd_next    = rcvd_reg;
        seq_next     = seq_reg;
        ticks_next   = ticks_reg;

        q_job        = '0;
        q_job.status = ST_OK;

        if (s_tuser)
        begin
            if (waiting_reg)
            begin
                if (ticks_inc >= lim)
                begin
                    // abandon: everything back to reset values
                    waiting_next = 1'b0;
                    peer_next    = '0;
                    tag_next     = '0;
                    total_next   = '0;
                    rcvd_next    = '0;
                    seq_next     = '0;
                    ticks_next   = '0;
                    q_job.to     = 1'b1;
                    q_job.snd    = peer_reg;
                end
                else
                begin
                    ticks_next = ticks_inc;
                end
            end
        end
        else if (len == 4'd0)
        begin
            q_job.status = ST_BAD_PCI;
        end
        else
        begin
            case (pci)
                PCI_SF:
                begin
                    if (low == 4'd0 || low > 4'd7 || low >= len)
                    begin
                        q_job.status = ST_BAD_PCI;
                    end
                    else
                    begin
                        waiting_next = 1'b0;
                        peer_next    = in_sender;
                        tag_next     = in_tag;
                        total_next   = {8'd0, low};
                        rcvd_next    = {8'd0, low};
                        seq_next     = '0;
                        ticks_next   = '0;
                        q_job.bytes  = b[7:1];
                        q_job.count  = low[2:0];
                        q_job.status = ST_COMPLETE;
                    end
                end
                PCI_FF:
                begin
                    if (len < FULL_FRAME || ff_total == 12'd0)
                    begin
                        q_job.status = ST_BAD_PCI;
                    end
                    else if (32'(ff_total) > MAX_MESSAGE)
                    begin
                        q_job.status = ST_OVERFLOW;
                    end
                    else
                    begin
                        peer_next   = in_sender;
                        tag_next    = in_tag;
                        total_next  = ff_total;
                        seq_next    = 4'd1;
                        ticks_next  = '0;
                        q_job.bytes = {b[0], b[7:2]};
                        q_job.fc    = 1'b1;
                        if (ff_total <= {9'd0, FF_CHUNK})
                        begin
                            // whole message fits in the first frame
                            waiting_next = 1'b0;
                            rcvd_next    = ff_total;
                            q_job.count  = ff_total[2:0];
                            q_job.status = ST_COMPLETE;
                        end
                        else
                        begin
                            waiting_next = 1'b1;
                            rcvd_next    = {9'd0, FF_CHUNK};
                            q_job.count  = FF_CHUNK;
                        end
                    end
                end
                PCI_CF:
                begin
                    if (!waiting_reg)
                    begin
                        q_job.status = ST_NO_FF;
                    end
                    else if (low != seq_reg)
                    begin
                        q_job.status = ST_BAD_SEQ;
                    end
                    else
                    begin
                        q_job.bytes = b[7:1];
                        q_job.count = take;
                        q_job.base  = rcvd_reg;
                        rcvd_next   = new_rcvd;
                        seq_next    = seq_reg + 4'd1;
                        ticks_next  = '0;
                        if (new_rcvd >= total_reg)
                        begin
                            waiting_next = 1'b0;
                            q_job.status = ST_COMPLETE;
                        end
                    end
                end
                PCI_FC:
                begin
                    q_job.status = ST_OK;
                end
                default:
                begin
                    q_job.status = ST_BAD_PCI;
                end
            endcase
        end

        // tag and total reported are those left after this transaction
        q_job.tag   = tag_next;
        q_job.total = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg <= 1'b0;
            peer_reg    <= '0;
            tag_reg     <= '0;
            total_reg   <= '0;
            rcvd_reg    <= '0;
            seq_reg     <= '0;
            ticks_reg   <= '0;
        end
        else if (accept)
        begin
            waiting_reg <= waiting_next;
            peer_reg    <= peer_next;
            tag_reg     <= tag_next;
            total_reg   <= total_next;
            rcvd_reg    <= rcvd_next;
            seq_reg     <= seq_next;
            ticks_reg   <= ticks_next;
        end
    end

endmodule

`default_nettype wire

[hdl/isotp_queue.sv]
// Two-entry job queue between front end and emitter.
`default_nettype none

module isotp_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire isotp_pkg::job_t       wdata,
    input  wire logic                  pop,
    output isotp_pkg::job_t            rdata,
    output isotp_pkg::q_status_t       stat
);
    import isotp_pkg::*;

    job_t       entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rdata      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

[hdl/isotp_back.sv]
// Emitter: turns each job into byte items and a closing status item.
`default_nettype none

module isotp_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire isotp_pkg::job_t       q_job,
    input  wire isotp_pkg::q_status_t  q_stat,
    output logic                       q_pop,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output isotp_pkg::item_t           out_item
);
    import isotp_pkg::*;

    job_t       cur_reg;
    logic       cur_valid_reg;
    logic [2:0] idx_reg;
    item_t      out_reg;
    logic       out_valid_reg;

    item_t      item;
    logic       out_load, advance, done;

    always_comb
    begin
        item       = '0;
        item.tag   = cur_reg.tag;
        item.total = cur_reg.total;
        if (idx_reg < cur_reg.count)
        begin
            item.is_byte    = 1'b1;
            item.out_byte   = cur_reg.bytes[idx_reg];
            item.out_offset = cur_reg.base + {9'd0, idx_reg};
            item.status     = ST_OK;
        end
        else
        begin
            item.status = cur_reg.status;
            item.fc     = cur_reg.fc;
            item.to     = cur_reg.to;
            item.snd    = cur_reg.snd;
            item.last   = 1'b1;
        end
    end

    assign out_load  = !out_valid_reg || out_ready;
    assign advance   = cur_valid_reg && out_load;
    assign done      = advance && (idx_reg == cur_reg.count);
    assign q_pop     = !q_stat.empty && (!cur_valid_reg || done);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_job;
        end
        if (advance)
        begin
            out_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (done)
            begin
                cur_valid_reg <= 1'b0;
            end
            else if (advance)
            begin
                idx_reg <= idx_reg + 3'd1;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/isotp_frame_reassembler.sv]
// Top level of the ISO-TP frame reassembler.
// Usage:
//   Slave stream carries one CAN frame payload or one time tick per transaction
//   (s_tuser high = tick). The front end classifies it and updates the
//   reassembly state in the cycle it is accepted, then queues a job.
//   The emitter turns each job into up to seven byte items (with offsets) and
//   one status item, which carries m_tlast. The message buffer is external.
//   Jobs pass the queue, the emitter's job register and the output register.
//   Each input gives N+1 results, N = bytes taken from the frame (0 to 7); one
//   result per cycle leaves the output register while m_tready is high and a
//   job is in hand. The two-entry job queue lets the front end take new frames
//   while the emitter works or the receiver stalls; s_tready drops when full.
//   Register timeout_ticks at byte address 0 over the APB port, reset 1000.
//   Reset clears the reassembly state, the queue and the output valid flag.
`default_nettype none

module isotp_frame_reassembler (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // APB configuration
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [isotp_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready,
    // frame_tag, sender_id, frame_len, b0 .. b7, zero pad
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [isotp_pkg::S_TDATA_W-1:0]    s_tdata,
    // cmd
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // out_byte, out_offset, status, flow_control_due, timed_out,
    // timeout_sender, msg_tag, msg_total, zero pad
    output logic [isotp_pkg::M_TDATA_W-1:0]         m_tdata,
    // is_byte
    output logic                                    m_tuser,
    output logic                                    m_tlast
);
    import isotp_pkg::*;

    logic [15:0] timeout_reg;
    logic        q_push, q_pop;
    job_t        push_job, head_job;
    q_status_t   q_stat;
    item_t       item;
    logic        addr_hit;

    // word decode: byte lanes within a register are ignored
    assign addr_hit = (paddr[PADDR_W-1:2] == ADDR_TIMEOUT[PADDR_W-1:2]);

    assign pready = 1'b1;
    assign prdata = addr_hit ? {16'd0, timeout_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (psel && penable && pwrite && pready && addr_hit)
        begin
            timeout_reg <= pwdata[15:0];
        end
    end

    isotp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .timeout_ticks (timeout_reg),
        .q_stat        (q_stat),
        .q_push        (q_push),
        .q_job         (push_job)
    );

    isotp_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (push_job),
        .pop   (q_pop),
        .rdata (head_job),
        .stat  (q_stat)
    );

    isotp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_job     (head_job),
        .q_stat    (q_stat),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (item)
    );

    assign m_tdata = {3'd0, item.total, item.tag, item.snd, item.to, item.fc,
                      item.status, item.out_offset, item.out_byte};
    assign m_tuser = item.is_byte;
    assign m_tlast = item.last;

endmodule

`default_nettype wire

[tb/isotp_reassembly_sb_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the ISO-TP reassembler: reassembly predictor and queue of expected results.
package isotp_reassembly_sb_pkg;

    import isotp_pkg::*;

    typedef struct packed {
        logic            tick;
        logic [7:0]      tag;
        logic [7:0]      sender;
        logic [3:0]      flen;
        logic [7:0][7:0] payload;   // payload[0] is the PCI byte
    } can_input_t;

    class reassembly_scoreboard;
        item_t       expected_items[$];
        int          mismatches;
        logic [15:0] timeout_ticks;
        logic        waiting_cf;
        logic [7:0]  cur_peer;
        logic [7:0]  cur_tag;
        logic [11:0] msg_length;
        logic [11:0] rx_count;
        logic [3:0]  exp_seq;
        logic [15:0] idle_ticks;

        function new();
            timeout_ticks = TIMEOUT_RESET;
            mismatches = 0;
            clear_message();
        endfunction

        function void clear_message();
            waiting_cf = 1'b0;
            cur_peer = '0;
            cur_tag = '0;
            msg_length = '0;
            rx_count = '0;
            exp_seq = '0;
            idle_ticks = '0;
        endfunction

        function void set_timeout(logic [15:0] value);
            timeout_ticks = value;
        endfunction

        function int pending();
            return expected_items.size();
        endfunction

        // tag and total are taken from the state at the moment of the call
        function void queue_item(logic isb, logic [7:0] data, int off, status_t st,
                                 logic fc, logic timed_out, logic [7:0] snd, logic lst);
            item_t it;
            it.is_byte = isb;
            it.out_byte = data;
            it.out_offset = 12'(off);
            it.status = st;
            it.fc = fc;
            it.to = timed_out;
            it.snd = snd;
            it.tag = cur_tag;
            it.total = msg_length;
            it.last = lst;
            expected_items.push_back(it);
        endfunction

        function void note_frame(can_input_t f);
            int          len;
            int          lim;
            int          tot;
            int          chunk;
            int          rem;
            int          take;
            logic [7:0]  peer;
            logic [3:0]  pci;
            logic [3:0]  low_nib;
            status_t     st;
            logic        fc;
            st = ST_OK;
            fc = 1'b0;
            if (f.tick)
            begin
                if (waiting_cf)
                begin
                    lim = (timeout_ticks == 0) ? 1 : int'(timeout_ticks);
                    if (idle_ticks != 16'hFFFF)
                        idle_ticks++;
                    if (int'(idle_ticks) >= lim)
                    begin
                        peer = cur_peer;
                        clear_message();
                        queue_item(1'b0, '0, 0, ST_OK, 1'b0, 1'b1, peer, 1'b1);
                        return;
                    end
                end
                queue_item(1'b0, '0, 0, ST_OK, 1'b0, 1'b0, '0, 1'b1);
                return;
            end

            len = (f.flen > FULL_FRAME) ? int'(FULL_FRAME) : int'(f.flen);
            pci = f.payload[0][7:4];
            low_nib = f.payload[0][3:0];

            if (len == 0)
            begin
                st = ST_BAD_PCI;
            end
            else
            begin
                case (pci)
                    PCI_SF:
                    begin
                        if (low_nib == 0 || low_nib > 7 || int'(low_nib) + 1 > len)
                        begin
                            st = ST_BAD_PCI;
                        end
                        else
                        begin
                            clear_message();
                            cur_peer = f.sender;
                            cur_tag = f.tag;
                            msg_length = 12'(low_nib);
                            rx_count = 12'(low_nib);
                            for (int i = 0; i < int'(low_nib); i++)
                                queue_item(1'b1, f.payload[1+i], i, ST_OK,
                                           1'b0, 1'b0, '0, 1'b0);
                            st = ST_COMPLETE;
                        end
                    end
                    PCI_FF:
                    begin
                        tot = int'({low_nib, f.payload[1]});
                        if (len < int'(FULL_FRAME) || tot == 0)
                        begin
                            st = ST_BAD_PCI;
                        end
                        else if (tot > MAX_MESSAGE)
                        begin
                            st = ST_OVERFLOW;
                        end
                        else
                        begin
                            chunk = (tot < int'(FF_CHUNK)) ? tot : int'(FF_CHUNK);
                            clear_message();
                            cur_peer = f.sender;
                            cur_tag = f.tag;
                            msg_length = 12'(tot);
                            exp_seq = 4'd1;
                            waiting_cf = 1'b1;
                            rx_count = 12'(chunk);
                            for (int i = 0; i < chunk; i++)
                                queue_item(1'b1, f.payload[2+i], i, ST_OK,
                                           1'b0, 1'b0, '0, 1'b0);
                            fc = 1'b1;
                            if (rx_count >= msg_length)
                            begin
                                waiting_cf = 1'b0;
                                st = ST_COMPLETE;
                            end
                        end
                    end
                    PCI_CF:
                    begin
                        if (!waiting_cf)
                        begin
                            st = ST_NO_FF;
                        end
                        else if (low_nib != exp_seq)
                        begin
                            st = ST_BAD_SEQ;
                        end
                        else
                        begin
                            rem = (msg_length > rx_count) ?
                                  int'(msg_length) - int'(rx_count) : 0;
                            take = (rem < len - 1) ? rem : len - 1;
                            for (int i = 0; i < take; i++)
                                queue_item(1'b1, f.payload[1+i], int'(rx_count) + i, ST_OK,
                                           1'b0, 1'b0, '0, 1'b0);
                            rx_count = rx_count + 12'(take);
                            exp_seq = exp_seq + 4'd1;
                            idle_ticks = '0;
                            if (rx_count >= msg_length)
                            begin
                                waiting_cf = 1'b0;
                                st = ST_COMPLETE;
                            end
                        end
                    end
                    PCI_FC: st = ST_OK;
                    default: st = ST_BAD_PCI;
                endcase
            end
            queue_item(1'b0, '0, 0, st, fc, 1'b0, '0, 1'b1);
        endfunction

        function void check_item(item_t got);
            item_t want;
            if (expected_items.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result is_byte=%0d byte=%h off=%0d st=%s last=%0d",
                             $time, got.is_byte, got.out_byte, got.out_offset,
                             got.status.name(), got.last);
                return;
            end
            want = expected_items.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: result mismatch", $time);
                    $display({"  exp: isb=%0d byte=%h off=%0d st=%s fc=%0d to=%0d",
                              " snd=%h tag=%h tot=%0d last=%0d"},
                             want.is_byte, want.out_byte, want.out_offset, want.status.name(),
                             want.fc, want.to, want.snd, want.tag, want.total, want.last);
                    $display({"  got: isb=%0d byte=%h off=%0d st=%s fc=%0d to=%0d",
                              " snd=%h tag=%h tot=%0d last=%0d"},
                             got.is_byte, got.out_byte, got.out_offset, got.status.name(),
                             got.fc, got.to, got.snd, got.tag, got.total, got.last);
                end
            end
        endfunction
    endclass

endpackage

[tb/tb_isotp_frame_reassembler.sv]
`timescale 1ns / 1ps
// Testbench top for the ISO-TP frame reassembler: stream and APB drivers, result monitor.
module tb_isotp_frame_reassembler;

    import isotp_pkg::*;
    import isotp_reassembly_sb_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;   // frame_tag, sender_id, frame_len, b0 .. b7, pad
    logic                   s_tuser = 1'b0; // cmd
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;        // out_byte, out_offset, status, fc, timed_out,
                                            // timeout_sender, msg_tag, msg_total, pad
    logic                   m_tuser;        // is_byte
    logic                   m_tlast;

    reassembly_scoreboard   sb;
    int                     tx_gap_max = 14;
    int                     rx_gap_max = 14;
    logic                   rx_hold = 1'b0;
    logic                   hold_go = 1'b0;
    int                     sent_items = 0;

    isotp_frame_reassembler dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // result monitor and receiver-side stalls
    initial
    begin
        int    stall;
        item_t got;
        stall = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.is_byte = m_tuser;
                got.out_byte = m_tdata[7:0];
                got.out_offset = m_tdata[19:8];
                got.status = status_t'(m_tdata[22:20]);
                got.fc = m_tdata[23];
                got.to = m_tdata[24];
                got.snd = m_tdata[32:25];
                got.tag = m_tdata[40:33];
                got.total = m_tdata[52:41];
                got.last = m_tlast;
                sb.check_item(got);
                stall = $urandom_range(0, rx_gap_max);
            end
            if (rx_hold || stall > 0)
            begin
                m_tready <= 1'b0;
                if (!rx_hold)
                    stall--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // long receiver hold-off while the sender keeps offering frames
    initial
    begin
        wait (hold_go);
        repeat (30) @(posedge clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
    end

    function automatic can_input_t make_frame(logic [7:0] b0, logic [7:0] b1, logic [3:0] flen);
        can_input_t f;
        f.tick = 1'b0;
        f.tag = 8'($urandom);
        f.sender = 8'($urandom);
        f.flen = flen;
        f.payload = {$urandom, $urandom};
        f.payload[0] = b0;
        f.payload[1] = b1;
        return f;
    endfunction

    task automatic push_item(can_input_t f);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= f.tick;
        s_tdata <= {4'b0, f.payload, f.flen, f.sender, f.tag};
        do @(posedge clk); while (!s_tready);
        sb.note_frame(f);
        sent_items++;
    endtask

    task automatic send(logic [7:0] b0, logic [7:0] b1, logic [3:0] flen);
        push_item(make_frame(b0, b1, flen));
    endtask

    task automatic send_tick();
        can_input_t f;
        f = make_frame(8'($urandom), 8'($urandom), 4'($urandom));
        f.tick = 1'b1;
        push_item(f);
    endtask

    task automatic send_noise();
        send(8'($urandom), 8'($urandom), 4'($urandom_range(0, 15)));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_timeout(data[15:0]);
    endtask

    task automatic set_timeout(int ticks);
        wait_drained();
        apb_write(ADDR_TIMEOUT, 32'(ticks));
    endtask

    // single frame, or first frame plus its consecutive frames, with the odd tick, stray frame or bad sequence
    task automatic send_message(int total);
        int         left;
        int         flen;
        int         pick;
        logic [3:0] seq;
        if (total <= 7 && $urandom_range(0, 1) == 1)
        begin
            send({PCI_SF, 4'(total)}, 8'($urandom), 4'($urandom_range(total + 1, 15)));
            return;
        end
        send({PCI_FF, 4'(total >> 8)}, 8'(total), 4'($urandom_range(8, 15)));
        left = (total > 6) ? total - 6 : 0;
        seq = 4'd1;
        while (left > 0)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                send_tick();
            else if (pick == 1)
                send_noise();
            else if (pick == 2)
                send({PCI_CF, seq + 4'($urandom_range(1, 15))}, 8'($urandom), 4'd8);
            else
            begin
                flen = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 8;
                send({PCI_CF, seq}, 8'($urandom), 4'(flen));
                flen = (flen > 8) ? 8 : flen;
                left = left - ((left < flen - 1) ? left : flen - 1);
                seq = seq + 4'd1;
            end
        end
    endtask

    task automatic random_phase(int items);
        int start;
        int pick;
        start = sent_items;
        while (sent_items - start < items)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
                send_message(($urandom_range(0, 7) == 0) ? $urandom_range(41, 130)
                                                         : $urandom_range(1, 40));
            else if (pick == 7)
                send_tick();
            else
                send_noise();
        end
    endtask

    initial
    begin
        can_input_t f;
        int         timeouts[5];
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: single frames, malformed frames, short first frames, stray frames
        send_tick();
        send({PCI_SF, 4'd1}, 8'($urandom), 4'd2);
        f = make_frame({PCI_SF, 4'd7}, 8'hFF, 4'd8);
        f.payload = '1;
        f.payload[0] = {PCI_SF, 4'd7};
        f.tag = 8'hFF;
        f.sender = 8'hFF;
        push_item(f);
        f.payload = '0;
        f.payload[0] = {PCI_SF, 4'd7};
        f.tag = 8'h00;
        f.sender = 8'h00;
        push_item(f);
        send({PCI_SF, 4'd3}, 8'($urandom), 4'd0);
        send({PCI_SF, 4'd7}, 8'($urandom), 4'd15);
        send({PCI_SF, 4'd0}, 8'($urandom), 4'd8);
        send({PCI_SF, 4'd8}, 8'($urandom), 4'd8);
        send({PCI_SF, 4'd5}, 8'($urandom), 4'd5);
        send({PCI_FF, 4'd0}, 8'd20, 4'd7);
        send({PCI_FF, 4'd0}, 8'd0, 4'd8);
        send({PCI_FF, 4'd0}, 8'd3, 4'd8);
        send({PCI_FF, 4'd0}, 8'd6, 4'd8);
        send({PCI_CF, 4'd1}, 8'($urandom), 4'd8);
        send({PCI_FC, 4'($urandom)}, 8'($urandom), 4'd8);
        send(8'h4A, 8'($urandom), 4'd8);
        send(8'hF0, 8'($urandom), 4'd8);
        // reassembly interrupted by a wrong sequence, a tick and a new first frame
        send({PCI_FF, 4'd0}, 8'd20, 4'd8);
        send({PCI_CF, 4'd2}, 8'($urandom), 4'd8);
        send({PCI_CF, 4'd1}, 8'($urandom), 4'd8);
        send_tick();
        send({PCI_FF, 4'd0}, 8'd9, 4'd8);
        send({PCI_CF, 4'd1}, 8'($urandom), 4'd8);
        send({PCI_FF, 4'hF}, 8'hFF, 4'd8);
        send({PCI_SF, 4'd4}, 8'($urandom), 4'd6);

        // timeout at the lowest setting, then after two ticks
        set_timeout(1);
        send({PCI_FF, 4'd0}, 8'd10, 4'd8);
        send_tick();
        send({PCI_CF, 4'd1}, 8'($urandom), 4'd8);
        set_timeout(2);
        send({PCI_FF, 4'd0}, 8'd30, 4'd8);
        send_tick();
        send({PCI_CF, 4'd1}, 8'($urandom), 4'd8);
        send_tick();
        send_tick();

        // long message, back to back: the sequence number wraps past 15
        set_timeout(65535);
        tx_gap_max = 0;
        rx_gap_max = 0;
        send({PCI_FF, 4'd0}, 8'd120, 4'd8);
        for (int i = 0; i < 17; i++)
            send({PCI_CF, 4'(i + 1)}, 8'($urandom), 4'd8);

        timeouts[0] = 3;
        timeouts[1] = 1;
        timeouts[2] = 65535;
        timeouts[3] = $urandom_range(2, 50);
        timeouts[4] = 1000;
        for (int p = 0; p < 5; p++)
        begin
            set_timeout(timeouts[p]);
            if (p == 0)
            begin
                tx_gap_max = 1;
                rx_gap_max = 14;
                hold_go <= 1'b1;
            end
            else
            begin
                tx_gap_max = 14 * $urandom_range(0, 1);
                rx_gap_max = 14 * $urandom_range(0, 1);
            end
            random_phase(18);
        end

        wait_drained();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
